FILE: src/assert_macros.svh
// Assertion helpers, sampled on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FPGAL_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FPGAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/fpgal_pkg.sv
package fpgal_pkg;

  localparam int BYTE_W            = 8;
  localparam int GRAN_REG_W        = 6;
  localparam int IN_ADDR_W         = 32;
  localparam int OUT_ADDR_W        = 32;
  localparam int OUT_IDX_W         = 5;
  localparam int S_TDATA_W         = 40;
  localparam int M_TDATA_W         = 48;
  localparam int DEF_MAX_GRANULE   = 32;
  localparam int DEF_ADDRESS_WIDTH = 32;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic clr;
    logic we;
    logic re;
  } store_ctl_t;

endpackage

FILE: src/fpgal_rem.sv
module fpgal_rem #(
  parameter int AW = 32,
  parameter int GW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] dividend,
  input  logic [GW-1:0] divisor,
  output logic          done,
  output logic [GW-1:0] rem
);

  localparam int CW = $clog2(AW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [AW-1:0] sh;
  logic [GW:0]   trial;
  logic [GW:0]   trial_sub;
  logic          fits;

  assign trial     = {rem, sh[AW-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(AW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (run) begin
      sh  <= sh << 1;
      rem <= fits ? trial_sub[GW-1:0] : trial[GW-1:0];
    end
  end

endmodule

FILE: src/fpgal_store.sv
module fpgal_store #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fpgal_pkg::store_ctl_t       ctl,
  input  logic [IW-1:0]               waddr,
  input  logic [fpgal_pkg::BYTE_W-1:0] wdata,
  input  logic [IW-1:0]               raddr,
  output logic [fpgal_pkg::BYTE_W-1:0] rdata
);

  import fpgal_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld;
  logic [BYTE_W-1:0] rd_mem;
  logic              rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rd_mem <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.re) begin
        rd_vld <= vld[raddr];
      end
      if (ctl.clr) begin
        vld <= '0;
      end else if (ctl.we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_vld ? rd_mem : ERASED_BYTE;

endmodule

FILE: src/flash_program_granule_aligner.sv
// Gathers a byte stream into granule-sized chunks (pre-filled with 0xFF) aligned to the
// program granule, and emits each full chunk, or the partial chunk at the end of a request,
// as granule bytes with its aligned base. A byte that does not close a chunk is taken in idle
// and then written to the chunk memory. The first byte of a request first passes through the
// bit-serial remainder unit that aligns the start address. In a chunk emit, each chunk byte
// is read from the registered chunk memory and then loaded into the output register;
// backpressure on the master side stalls the emit. No input is taken during the remainder or
// the emit. The chunk memory clears through per-entry valid bits, so it needs no clearing
// pass after reset. cfg_data (the program granule) may only be written while the block is
// idle. A granule of 0 is treated as 1, and a granule above MAX_GRANULE as MAX_GRANULE.
module flash_program_granule_aligner #(
  parameter int MAX_GRANULE   = fpgal_pkg::DEF_MAX_GRANULE,
  parameter int ADDRESS_WIDTH = fpgal_pkg::DEF_ADDRESS_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpgal_pkg::GRAN_REG_W-1:0]  cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [31:0] start_offset, [39:32] data_byte
  input  logic [fpgal_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] first_of_request
  input  logic                              s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] chunk_base, [36:32] byte_index, [44:37] byte_value, [47:45] zero
  output logic [fpgal_pkg::M_TDATA_W-1:0]   m_tdata,
  // [0] request_done
  output logic                              m_tuser,
  output logic                              m_tlast
);

  import fpgal_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = ADDRESS_WIDTH;
  localparam int GW = $clog2(MAX_GRANULE + 1);
  localparam int IW = (MAX_GRANULE > 1) ? $clog2(MAX_GRANULE) : 1;

  state_t state, state_next;

  logic [GRAN_REG_W-1:0] gran_reg;
  logic [GW-1:0]         g_eff;
  logic [GW-1:0]         g_m1;

  logic [IW-1:0]     fill_pos;
  logic [AW-1:0]     chunk_addr;
  logic [AW-1:0]     addr_buf;
  logic [BYTE_W-1:0] byte_buf;
  logic              last_buf;
  logic [IW-1:0]     idx;

  logic [GW-1:0] fill_ext;
  logic [GW-1:0] pos_g;
  logic [IW-1:0] pos;
  logic          chunk_full;
  logic          idx_last;

  logic          rem_start;
  logic          rem_done;
  logic [GW-1:0] rem_val;

  store_ctl_t        st_ctl;
  logic [BYTE_W-1:0] st_rdata;
  logic              load_out;

  logic [OUT_ADDR_W-1:0] ob_base;
  logic [OUT_IDX_W-1:0]  ob_idx;
  logic [BYTE_W-1:0]     ob_val;

  logic accept;
  logic out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gran_reg <= GRAN_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      gran_reg <= cfg_data;
    end
  end

  always_comb begin
    if (gran_reg == '0) begin
      g_eff = GW'(1);
    end else if ({1'b0, gran_reg} > (GRAN_REG_W + 1)'(MAX_GRANULE)) begin
      g_eff = GW'(MAX_GRANULE);
    end else begin
      g_eff = GW'(gran_reg);
    end
  end

  assign g_m1       = g_eff - GW'(1);
  assign fill_ext   = GW'(fill_pos);
  assign pos_g      = (fill_ext >= g_eff) ? g_m1 : fill_ext;
  assign pos        = IW'(pos_g);
  assign chunk_full = (pos_g == g_m1) || last_buf;
  assign idx_last   = (GW'(idx) == g_m1);

  fpgal_rem #(
    .AW (AW),
    .GW (GW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (AW'(s_tdata[IN_ADDR_W-1:0])),
    .divisor  (g_eff),
    .done     (rem_done),
    .rem      (rem_val)
  );

  fpgal_store #(
    .DEPTH (MAX_GRANULE),
    .IW    (IW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (st_ctl),
    .waddr (pos),
    .wdata (byte_buf),
    .raddr (idx),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rem_start  = 1'b0;
    st_ctl     = '0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rem_start  = s_tuser;
          state_next = s_tuser ? ST_DIV : ST_WRITE;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          st_ctl.clr = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        st_ctl.we  = 1'b1;
        state_next = chunk_full ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        st_ctl.re  = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_free) begin
          load_out = 1'b1;
          if (idx_last) begin
            st_ctl.clr = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pos   <= '0;
      chunk_addr <= '0;
    end else begin
      if (state == ST_DIV && rem_done) begin
        chunk_addr <= addr_buf - AW'(rem_val);
        fill_pos   <= IW'(rem_val);
      end else if (state == ST_WRITE && !chunk_full) begin
        fill_pos <= pos + IW'(1);
      end else if (state == ST_SEND && load_out && idx_last) begin
        fill_pos   <= '0;
        chunk_addr <= chunk_addr + AW'(g_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_buf <= s_tdata[IN_ADDR_W +: BYTE_W];
      last_buf <= s_tlast;
      addr_buf <= AW'(s_tdata[IN_ADDR_W-1:0]);
    end
    if (state == ST_WRITE) begin
      idx <= '0;
    end else if (load_out) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ob_base <= OUT_ADDR_W'(chunk_addr);
      ob_idx  <= OUT_IDX_W'(idx);
      ob_val  <= st_rdata;
      m_tlast <= idx_last;
      m_tuser <= idx_last && last_buf;
    end
  end

  assign m_tdata = {(M_TDATA_W - OUT_ADDR_W - OUT_IDX_W - BYTE_W)'(0), ob_val, ob_idx, ob_base};

  `FPGAL_ASSERT(a_done_on_last, m_tvalid && m_tuser, m_tlast, "request_done without last_of_chunk")
  `FPGAL_ASSERT(a_idx_in_gran, m_tvalid, GW'(ob_idx) <= g_m1, "byte_index beyond granule")
  `FPGAL_ASSERT(a_rem_below_gran, rem_done, rem_val < g_eff, "remainder not below granule")
  `FPGAL_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "ready right after an accept")

endmodule
